### design/ibu_pkg.sv
// Package for the instruction breakpoint unit: word types, action and status
// codes, token type of the cell chain and default parameter values.
// No dependencies.
`default_nettype none

package ibu_pkg;

  localparam int TableDepthDef = 32;
  localparam int AddrBitsDef   = 16;

  // Action codes of an input word.
  localparam logic [1:0] ACT_TOGGLE   = 2'd0;
  localparam logic [1:0] ACT_QUERY    = 2'd1;
  localparam logic [1:0] ACT_SET_TEMP = 2'd2;
  localparam logic [1:0] ACT_EXECUTE  = 2'd3;

  // Status codes of a result word.
  localparam logic [1:0] ST_NONE    = 2'd0;
  localparam logic [1:0] ST_ADDED   = 2'd1;
  localparam logic [1:0] ST_REMOVED = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic [1:0]  action;
    logic [1:0]  code_range;
    logic [15:0] code_address;
    logic        watch_hit;
    logic        at_code_end;
  } ibu_in_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] status;
  } ibu_out_t;

  // Search token handed from one cell to the next.
  typedef struct packed {
    logic tok;
    logic found;
  } ibu_tok_t;

endpackage

`default_nettype wire

### design/ibu_cell.sv
// One cell of the breakpoint chain: holds one table entry, compares it with
// the search key as the token passes and shifts entries to close a gap.
// Depends on ibu_pkg.
`default_nettype none

module ibu_cell
  import ibu_pkg::*;
#(
  parameter int INDEX = 0,
  parameter int CW    = 6,
  parameter int AW    = AddrBitsDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [CW-1:0] count_i,
  input  wire logic [1:0]    key_range_i,
  input  wire logic [AW-1:0] key_addr_i,
  input  wire logic          remove_i,
  input  wire logic          append_i,
  input  wire ibu_tok_t      tok_i,
  output ibu_tok_t           tok_o,
  output logic               shift_req_o,
  input  wire logic          shift_req_i,
  input  wire logic [1:0]    right_range_i,
  input  wire logic [AW-1:0] right_addr_i,
  output logic [1:0]         range_o,
  output logic [AW-1:0]      addr_o
);

  logic [1:0]    range_q, range_d;
  logic [AW-1:0] addr_q, addr_d;
  ibu_tok_t      tok_q, tok_d;
  logic          valid, match;

  // Only entries below the fill count take part in a search.
  assign valid = (CW'(INDEX) < count_i);
  assign match = tok_i.tok && valid && (range_q == key_range_i) && (addr_q == key_addr_i);

  always_comb begin
    tok_d.tok   = tok_i.tok;
    tok_d.found = tok_i.found | match;
  end

  // Once a removal has matched an entry to the left, this entry moves one place left.
  assign shift_req_o = tok_i.tok && tok_i.found && remove_i;

  always_comb begin
    range_d = range_q;
    addr_d  = addr_q;
    if (append_i && (count_i == CW'(INDEX))) begin
      range_d = key_range_i;
      addr_d  = key_addr_i;
    end else if (shift_req_i) begin
      range_d = right_range_i;
      addr_d  = right_addr_i;
    end
  end

  always_ff @(posedge clk_i) begin
    range_q <= range_d;
    addr_q  <= addr_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o   = tok_q;
  assign range_o = range_q;
  assign addr_o  = addr_q;

endmodule

`default_nettype wire

### design/instruction_breakpoint_unit_top.sv
// Top level of the instruction breakpoint unit: control sequencer, temporary
// breakpoint, single-step register and the chain of table cells.
// Depends on ibu_pkg and ibu_cell.
`default_nettype none

// The unit keeps a packed table of up to TABLE_DEPTH breakpoints in a row of
// cells, plus one one-shot temporary breakpoint, and answers each input word
// with exactly one result word. A toggle, a query or an executed instruction
// sends a search token down the cell row, one cell per cycle; its result is
// formed once the token has left the tail cell. Setting the temporary
// breakpoint skips the search. A removal closes the gap as the token passes,
// each later entry moving one cell towards the head. One word is worked on at
// a time, but a new word is accepted while the previous result still waits to
// be taken; a stalled result output only holds the unit up when the previous
// result is still waiting as the next one is ready to go out.
// The single_step register (reset 1) is written through cfg_we_i and
// cfg_data_i; the user must write it only while the unit is idle, as the
// unit itself does not enforce this.

module instruction_breakpoint_unit_top
  import ibu_pkg::*;
#(
  parameter int TABLE_DEPTH = TableDepthDef,
  parameter int ADDR_BITS   = AddrBitsDef
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  wire ibu_in_t in_word_i,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output ibu_out_t     out_word_o,
  input  wire logic    cfg_we_i,
  input  wire logic    cfg_data_i
);

  localparam int D  = TABLE_DEPTH;
  localparam int AW = ADDR_BITS;
  localparam int CW = $clog2(D + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;
  localparam logic [1:0] S_PUSH = 2'd3;

  logic [1:0]    state_q, state_d;
  logic          start_q, start_d;
  logic          found_q, found_d;
  logic [CW-1:0] count_q, count_d;
  logic          step_q, step_d;
  logic [1:0]    temp_range_q, temp_range_d;
  logic [AW-1:0] temp_addr_q, temp_addr_d;

  // Words held for the item in flight; no reset needed.
  logic [1:0]    op_q, op_d;
  logic [1:0]    key_range_q, key_range_d;
  logic [AW-1:0] key_addr_q, key_addr_d;
  logic          watch_q, watch_d;
  logic          at_end_q, at_end_d;
  ibu_out_t      res_q, res_d;

  logic          out_valid_q, out_valid_d;
  ibu_out_t      out_word_q, out_word_d;

  logic          accept, append;
  logic [AW+15:0] addr_ext;

  ibu_tok_t      tok_chain [D+1];
  logic          shift_req [D+1];
  logic [1:0]    ent_range [D+1];
  logic [AW-1:0] ent_addr  [D+1];

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // The address is stored and compared at ADDR_BITS bits.
  assign addr_ext = {{AW{1'b0}}, in_word_i.code_address};

  // A toggle without a match appends at the fill count when there is room.
  assign append = (state_q == S_FIN) && (op_q == ACT_TOGGLE) && !found_q &&
                  (count_q != CW'(D));

  // The token enters the head cell in the cycle after acceptance.
  assign tok_chain[0].tok   = start_q;
  assign tok_chain[0].found = 1'b0;
  assign shift_req[D]       = 1'b0;
  assign ent_range[D]       = '0;
  assign ent_addr[D]        = '0;

  for (genvar i = 0; i < D; i++) begin : g_cell
    ibu_cell #(
      .INDEX (i),
      .CW    (CW),
      .AW    (AW)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .count_i       (count_q),
      .key_range_i   (key_range_q),
      .key_addr_i    (key_addr_q),
      .remove_i      (op_q == ACT_TOGGLE),
      .append_i      (append),
      .tok_i         (tok_chain[i]),
      .tok_o         (tok_chain[i+1]),
      .shift_req_o   (shift_req[i]),
      .shift_req_i   (shift_req[i+1]),
      .right_range_i (ent_range[i+1]),
      .right_addr_i  (ent_addr[i+1]),
      .range_o       (ent_range[i]),
      .addr_o        (ent_addr[i])
    );
  end

  always_comb begin
    state_d      = state_q;
    start_d      = 1'b0;
    found_d      = found_q;
    count_d      = count_q;
    temp_range_d = temp_range_q;
    temp_addr_d  = temp_addr_q;
    op_d         = op_q;
    key_range_d  = key_range_q;
    key_addr_d   = key_addr_q;
    watch_d      = watch_q;
    at_end_d     = at_end_q;
    res_d        = res_q;
    out_valid_d  = out_valid_q;
    out_word_d   = out_word_q;
    step_d       = cfg_we_i ? cfg_data_i : step_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d        = in_word_i.action;
          key_range_d = in_word_i.code_range;
          key_addr_d  = addr_ext[AW-1:0];
          watch_d     = in_word_i.watch_hit;
          at_end_d    = in_word_i.at_code_end;
          found_d     = 1'b0;
          if (in_word_i.action == ACT_SET_TEMP) begin
            state_d = S_FIN;
          end else begin
            start_d = 1'b1;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // The token has left the tail cell: the search is complete.
        if (tok_chain[D].tok) begin
          found_d = tok_chain[D].found;
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        res_d.hit    = 1'b0;
        res_d.status = ST_NONE;
        unique case (op_q)
          ACT_TOGGLE: begin
            if (found_q) begin
              count_d      = count_q - CW'(1);
              res_d.status = ST_REMOVED;
            end else if (count_q == CW'(D)) begin
              res_d.status = ST_FULL;
            end else begin
              count_d      = count_q + CW'(1);
              res_d.status = ST_ADDED;
            end
          end
          ACT_QUERY: begin
            res_d.hit = found_q;
          end
          ACT_SET_TEMP: begin
            temp_range_d = key_range_q;
            temp_addr_d  = key_addr_q;
          end
          default: begin
            // Watch hit and single stepping take precedence over, and so
            // preserve, the temporary breakpoint.
            if (watch_q || step_q) begin
              res_d.hit = 1'b1;
            end else if ((temp_range_q == key_range_q) && (temp_addr_q == key_addr_q)) begin
              temp_range_d = 2'd0;
              res_d.hit    = 1'b1;
            end else if (found_q || at_end_q) begin
              res_d.hit = 1'b1;
            end
          end
        endcase
        state_d = S_PUSH;
      end
      default: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_word_d  = res_q;
          state_d     = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      start_q      <= 1'b0;
      found_q      <= 1'b0;
      count_q      <= '0;
      step_q       <= 1'b1;
      temp_range_q <= '0;
      temp_addr_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      start_q      <= start_d;
      found_q      <= found_d;
      count_q      <= count_d;
      step_q       <= step_d;
      temp_range_q <= temp_range_d;
      temp_addr_q  <= temp_addr_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    key_range_q <= key_range_d;
    key_addr_q  <= key_addr_d;
    watch_q     <= watch_d;
    at_end_q    <= at_end_d;
    res_q       <= res_d;
    out_word_q  <= out_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

`default_nettype wire
